@@ rtl/semaphore_wait_queue_table_macros.svh @@
// ---------------------------------------------------------------------------
// semaphore_wait_queue_table_macros
// Assertion macros for the semaphore wait queue table.
// ---------------------------------------------------------------------------
`ifndef SEMAPHORE_WAIT_QUEUE_TABLE_MACROS_SVH
`define SEMAPHORE_WAIT_QUEUE_TABLE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SWQ_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication checked outside reset
`define SWQ_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

@@ rtl/swqt_pkg.sv @@
// ---------------------------------------------------------------------------
// swqt_pkg
// Shared types and constants of the semaphore wait queue table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package swqt_pkg;
	localparam int NUM_PROCS_DEF = 32;
	localparam int KEY_BITS_DEF  = 32;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_PEEK   = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_POP    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOFREE   = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_BLOCKED  = 2'd3
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_EXEC,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture request
		logic rd;     // read process tables
		logic scan;   // search descriptors
		logic exec;   // update tables, build result
	} cmd_t;
endpackage

@@ rtl/semaphore_wait_queue_table.sv @@
// ---------------------------------------------------------------------------
// semaphore_wait_queue_table
// Active semaphore list: keyed FIFO queues of blocked processes.
// ---------------------------------------------------------------------------
// One item is in flight at a time. After the accept cycle the block reads
// the process entry, searches all descriptors for the key and a free slot,
// then updates the queue links and registers the result; out_valid rises
// in the DONE state after the update and holds until the result is taken.
// in_ready returns the cycle after that, so a new item is accepted only
// once the previous result has been taken; an output stall delays it.
// Status codes: ok, no free descriptor, not found or empty, already blocked.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module semaphore_wait_queue_table import swqt_pkg::*; #(
	parameter int NUM_PROCS = NUM_PROCS_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] sem_key,
	input  logic [4:0]  proc_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        proc_valid,
	output logic [4:0]  proc_out
);
	cmd_t cmd;

	// sequencer
	swqt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd
	);

	// tables and result register
	swqt_dp #(.NUM_PROCS(NUM_PROCS), .KEY_BITS(KEY_BITS)) u_dp (
		.clk, .arst_n, .cmd, .req_type, .sem_key, .proc_id,
		.status, .proc_valid, .proc_out
	);
endmodule

@@ rtl/swqt_ctrl.sv @@
// ---------------------------------------------------------------------------
// swqt_ctrl
// Request sequencer: load, read, search, execute, deliver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module swqt_ctrl import swqt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

@@ rtl/swqt_dp.sv @@
// ---------------------------------------------------------------------------
// swqt_dp
// Descriptor and process tables with key search and queue link update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module swqt_dp import swqt_pkg::*; #(
	parameter int NUM_PROCS = NUM_PROCS_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [1:0]  req_type,
	input  logic [31:0] sem_key,
	input  logic [4:0]  proc_id,
	output logic [1:0]  status,
	output logic        proc_valid,
	output logic [4:0]  proc_out
);
	localparam int PW = $clog2(NUM_PROCS);
	localparam int DW = $clog2(NUM_PROCS + 1);

	logic [NUM_PROCS-1:0] desc_active_q, proc_blocked_q;
	logic [KEY_BITS-1:0]  desc_key_q [NUM_PROCS];
	logic [PW-1:0]        desc_head_q [NUM_PROCS];
	logic [PW-1:0]        desc_tail_q [NUM_PROCS];
	logic [KEY_BITS-1:0]  proc_key_q [NUM_PROCS];
	logic [PW-1:0]        proc_next_q [NUM_PROCS];
	logic [PW-1:0]        proc_prev_q [NUM_PROCS];

	req_t                req_q;
	logic [KEY_BITS-1:0] key_q;
	logic                pid_ok_q;
	logic [PW-1:0]       pid_q;
	logic                blk_q;
	logic [KEY_BITS-1:0] skey_q;
	logic                hit_q, free_ok_q;
	logic [PW-1:0]       hit_idx_q, free_idx_q;
	logic [1:0]          status_q;
	logic                pv_q;
	logic [4:0]          pout_q;

	logic [KEY_BITS-1:0] skey;
	logic                hit, free_ok;
	logic [PW-1:0]       hit_idx, free_idx;

	// search key: named removal uses the key the process waits on
	always_comb begin
		skey = (req_q == REQ_REMOVE) ? skey_q : key_q;
		hit = 1'b0;
		hit_idx = '0;
		free_ok = 1'b0;
		free_idx = '0;
		for (int d = NUM_PROCS - 1; d >= 0; d--) begin
			if (desc_active_q[d] && desc_key_q[d] == skey) begin
				hit = 1'b1;
				hit_idx = PW'(d);
			end
			if (!desc_active_q[d]) begin
				free_ok = 1'b1;
				free_idx = PW'(d);
			end
		end
	end

	logic [DW-1:0] pid_ext;
	assign pid_ext = DW'(proc_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_active_q  <= '0;
			proc_blocked_q <= '0;
		end else if (cmd.exec) begin
			if (req_q == REQ_INSERT && pid_ok_q && !blk_q &&
			    (hit_q || free_ok_q)) begin
				proc_blocked_q[pid_q] <= 1'b1;
				if (!hit_q) desc_active_q[free_idx_q] <= 1'b1;
			end else if ((req_q == REQ_REMOVE && pid_ok_q && blk_q && hit_q) ||
			             (req_q == REQ_POP && hit_q)) begin
				proc_blocked_q[(req_q == REQ_POP) ? desc_head_q[hit_idx_q] : pid_q]
					<= 1'b0;
				if (desc_head_q[hit_idx_q] == desc_tail_q[hit_idx_q])
					desc_active_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	logic [PW-1:0] p, h, t, pr, nx;
	always_comb begin
		h  = desc_head_q[hit_idx_q];
		t  = desc_tail_q[hit_idx_q];
		p  = (req_q == REQ_POP) ? h : pid_q;
		pr = proc_prev_q[p];
		nx = proc_next_q[p];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req_t'(req_type);
			key_q    <= KEY_BITS'(sem_key);
			pid_ok_q <= pid_ext < DW'(NUM_PROCS);
			pid_q    <= PW'(proc_id);
		end
		if (cmd.rd) begin
			blk_q  <= proc_blocked_q[pid_q];
			skey_q <= proc_key_q[pid_q];
		end
		if (cmd.scan) begin
			hit_q      <= hit;
			hit_idx_q  <= hit_idx;
			free_ok_q  <= free_ok;
			free_idx_q <= free_idx;
		end
		if (cmd.exec) begin
			status_q <= ST_NOTFOUND;
			pv_q     <= 1'b0;
			pout_q   <= '0;
			case (req_q)
				REQ_INSERT: begin
					if (pid_ok_q) begin
						if (blk_q) status_q <= ST_BLOCKED;
						else if (hit_q) begin
							proc_next_q[t] <= pid_q;
							proc_prev_q[pid_q] <= t;
							desc_tail_q[hit_idx_q] <= pid_q;
							proc_key_q[pid_q] <= key_q;
							status_q <= ST_OK;
						end else if (free_ok_q) begin
							desc_key_q[free_idx_q]  <= key_q;
							desc_head_q[free_idx_q] <= pid_q;
							desc_tail_q[free_idx_q] <= pid_q;
							proc_key_q[pid_q] <= key_q;
							status_q <= ST_OK;
						end else status_q <= ST_NOFREE;
					end
				end
				REQ_PEEK: begin
					if (hit_q) begin
						status_q <= ST_OK;
						pv_q <= 1'b1;
						pout_q <= 5'(h);
					end
				end
				default: begin
					if ((req_q == REQ_POP || (pid_ok_q && blk_q)) && hit_q) begin
						status_q <= ST_OK;
						pv_q <= 1'b1;
						pout_q <= 5'(p);
						if (h == p && t == p) begin
						end else if (h == p) desc_head_q[hit_idx_q] <= nx;
						else if (t == p) desc_tail_q[hit_idx_q] <= pr;
						else begin
							proc_next_q[pr] <= nx;
							proc_prev_q[nx] <= pr;
						end
					end
				end
			endcase
		end
	end

	assign status     = status_q;
	assign proc_valid = pv_q;
	assign proc_out   = pout_q;
endmodule

@@ rtl/swqt_checker.sv @@
// ---------------------------------------------------------------------------
// swqt_checker
// Port-level checks of the semaphore wait queue table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "semaphore_wait_queue_table_macros.svh"
module swqt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic       proc_valid,
	input logic [4:0] proc_out
);
	`SWQ_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`SWQ_ASSERT_IMP(a_pv_ok, clk, arst_n, out_valid && proc_valid, status == 2'd0)
	`SWQ_ASSERT_IMP(a_pout_zero, clk, arst_n, out_valid && !proc_valid, proc_out == 5'd0)
	`SWQ_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule

bind semaphore_wait_queue_table swqt_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.status, .proc_valid, .proc_out
);
